// ===== sv/qst_pkg.sv =====
// Shared types and constants for the quad sensor tracker drive.
// Holds the request and result structs, register indexes and drive codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qst_pkg;

  // Field widths fixed by the interface
  localparam int SAMPLE_BITS    = 12;
  localparam int OFS_BITS       = 12;
  localparam int DEADBAND_BITS  = 14;
  localparam int COEFF_BITS     = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int LEVEL_BITS     = 32;
  localparam int DRIVE_BITS     = 2;
  localparam int LANES          = 4;
  localparam int FRAC_BITS_DEF  = 16;

  // Offset-corrected sample width: unsigned sample plus signed offset
  localparam int X_BITS = ((SAMPLE_BITS > OFS_BITS) ? SAMPLE_BITS : OFS_BITS) + 2;

  // Lane order of the four sensors
  localparam int LANE_LB = 0;
  localparam int LANE_RB = 1;
  localparam int LANE_RT = 2;
  localparam int LANE_LT = 3;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OFS_LB   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OFS_RB   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OFS_RT   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OFS_LT   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEADBAND = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COEFF    = 3'd5;

  // Register reset values
  localparam logic signed [OFS_BITS-1:0]   OFS_LB_RST   = -12'sd66;
  localparam logic signed [OFS_BITS-1:0]   OFS_RB_RST   = -12'sd270;
  localparam logic signed [OFS_BITS-1:0]   OFS_RT_RST   = 12'sd203;
  localparam logic signed [OFS_BITS-1:0]   OFS_LT_RST   = 12'sd131;
  localparam logic [DEADBAND_BITS-1:0]     DEADBAND_RST = 14'd100;
  localparam logic [COEFF_BITS-1:0]        COEFF_RST    = 16'd655;

  // Drive codes
  localparam logic [DRIVE_BITS-1:0] DRIVE_STOP = 2'd0;
  localparam logic [DRIVE_BITS-1:0] DRIVE_FWD  = 2'd1;
  localparam logic [DRIVE_BITS-1:0] DRIVE_REV  = 2'd2;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_left_bottom;
    logic [SAMPLE_BITS-1:0] sample_right_bottom;
    logic [SAMPLE_BITS-1:0] sample_right_top;
    logic [SAMPLE_BITS-1:0] sample_left_top;
  } sample_t;

  typedef struct packed {
    logic [DRIVE_BITS-1:0] tilt_drive;
    logic [DRIVE_BITS-1:0] pan_drive;
  } drive_t;

endpackage

`default_nettype wire

// ===== sv/qst_lane.sv =====
// One sensor lane: offset correction and exponential smoothing of one level.
// Holds the smoothed level register. Depends on qst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qst_lane #(
  parameter int FRAC_BITS = qst_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  load,
  input  logic                                  primed,
  input  logic [qst_pkg::SAMPLE_BITS-1:0]       sample,
  input  logic signed [qst_pkg::OFS_BITS-1:0]   offset,
  input  logic [qst_pkg::COEFF_BITS-1:0]        coeff,
  output logic signed [qst_pkg::LEVEL_BITS-1:0] level
);
  import qst_pkg::*;

  localparam int TW = X_BITS + FRAC_BITS;
  localparam int DW = ((TW > LEVEL_BITS) ? TW : LEVEL_BITS) + 1;
  localparam int PW = DW + COEFF_BITS + 1;
  localparam int NW = DW + 2;
  localparam logic signed [PW-1:0] ROUND_HALF =
    {{(PW-COEFF_BITS){1'b0}}, 1'b1, {(COEFF_BITS-1){1'b0}}};

  logic signed [X_BITS-1:0]     x;
  logic signed [TW-1:0]         target;
  logic signed [DW-1:0]         diff;
  logic signed [PW-1:0]         prod;
  logic signed [DW:0]           step;
  logic signed [NW-1:0]         upd;
  logic signed [NW-1:0]         nxt;
  logic                         fits;
  logic signed [LEVEL_BITS-1:0] level_next;

  // Correct the sample and scale it to the level format
  assign x      = $signed({{(X_BITS-SAMPLE_BITS){1'b0}}, sample}) + X_BITS'(offset);
  assign target = {x, {FRAC_BITS{1'b0}}};

  // Move toward the target by coeff, rounding half up
  assign diff = DW'(target) - DW'(level);
  assign prod = PW'(diff) * PW'($signed({1'b0, coeff})) + ROUND_HALF;
  assign step = $signed(prod[PW-1:COEFF_BITS]);
  assign upd  = NW'(level) + NW'(step);

  // First request loads the target directly
  assign nxt = primed ? upd : NW'(target);

  // Saturate to the level range
  assign fits = (&nxt[NW-1:LEVEL_BITS-1]) || ~(|nxt[NW-1:LEVEL_BITS-1]);
  always_comb begin
    if (fits) begin
      level_next = nxt[LEVEL_BITS-1:0];
    end else if (nxt[NW-1]) begin
      level_next = {1'b1, {(LEVEL_BITS-1){1'b0}}};
    end else begin
      level_next = {1'b0, {(LEVEL_BITS-1){1'b1}}};
    end
  end

  // Advance the level on each accepted request
  always_ff @(posedge clk) begin
    if (load) begin
      level <= level_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/qst_merge.sv =====
// Merge stage: rounds the pair sums of the four levels and picks drive codes.
// Holds the result register and its handshake. Depends on qst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qst_merge #(
  parameter int FRAC_BITS = qst_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   take,
  output logic                                   ready,
  input  logic signed [qst_pkg::LEVEL_BITS-1:0]  level [qst_pkg::LANES],
  input  logic [qst_pkg::DEADBAND_BITS-1:0]      deadband,
  output logic                                   drive_valid,
  input  logic                                   drive_ready,
  output qst_pkg::drive_t                        drive
);
  import qst_pkg::*;

  localparam int SUM_BITS = LEVEL_BITS + 1;
  localparam int ADD_BITS = SUM_BITS + 1;
  localparam int RW       = ADD_BITS - FRAC_BITS;
  localparam int DFW      = RW + 2;
  localparam logic [ADD_BITS-1:0] HALF =
    {{(ADD_BITS-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  // Round a pair sum to an integer, half away from zero
  function automatic logic signed [RW:0] round_pair(
    input logic signed [LEVEL_BITS-1:0] a,
    input logic signed [LEVEL_BITS-1:0] b
  );
    logic signed [SUM_BITS-1:0] s;
    logic [SUM_BITS-1:0]        mag;
    logic [ADD_BITS-1:0]        rsum;
    logic [RW-1:0]              r;
    s    = SUM_BITS'(a) + SUM_BITS'(b);
    mag  = s[SUM_BITS-1] ? SUM_BITS'(-s) : s;
    rsum = {1'b0, mag} + HALF;
    r    = rsum[ADD_BITS-1:FRAC_BITS];
    return s[SUM_BITS-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  // Stop inside the deadband, else drive toward the brighter side
  function automatic logic [DRIVE_BITS-1:0] drive_code(
    input logic signed [RW:0]         hi,
    input logic signed [RW:0]         lo,
    input logic [DEADBAND_BITS-1:0]   band
  );
    logic signed [DFW-1:0] d;
    logic [DFW-1:0]        mag;
    d   = DFW'(hi) - DFW'(lo);
    mag = d[DFW-1] ? DFW'(-d) : d;
    if (mag <= {{(DFW-DEADBAND_BITS){1'b0}}, band}) begin
      return DRIVE_STOP;
    end
    return d[DFW-1] ? DRIVE_REV : DRIVE_FWD;
  endfunction

  logic signed [RW:0] top_sum;
  logic signed [RW:0] bottom_sum;
  logic signed [RW:0] left_sum;
  logic signed [RW:0] right_sum;
  drive_t             drive_next;

  assign top_sum    = round_pair(level[LANE_RT], level[LANE_LT]);
  assign bottom_sum = round_pair(level[LANE_LB], level[LANE_RB]);
  assign left_sum   = round_pair(level[LANE_LB], level[LANE_LT]);
  assign right_sum  = round_pair(level[LANE_RB], level[LANE_RT]);

  always_comb begin
    drive_next.tilt_drive = drive_code(top_sum, bottom_sum, deadband);
    drive_next.pan_drive  = drive_code(left_sum, right_sum, deadband);
  end

  // Output register takes a new result whenever it is empty or draining
  assign ready = !drive_valid || drive_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (take) begin
      drive_valid <= 1'b1;
    end else if (drive_ready) begin
      drive_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      drive <= drive_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/quad_sensor_tracker_drive_top.sv =====
// Quad sensor tracker drive: four smoothing lanes feed a rounding and deadband merge.
// Path: level registers take each request, then the result register. Throughput: one request
// per cycle unless results stall; each lane's single multiply-add closes its level loop.
// Reset: synchronous, clears handshake state and priming, restores register defaults.
// Depends on qst_pkg, qst_lane and qst_merge.
`timescale 1ns / 1ps
`default_nettype none

module quad_sensor_tracker_drive_top #(
  parameter int FRAC_BITS = qst_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [qst_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [qst_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 sample_valid,
  output logic                                 sample_ready,
  input  qst_pkg::sample_t                     sample,
  output logic                                 drive_valid,
  input  logic                                 drive_ready,
  output qst_pkg::drive_t                      drive
);
  import qst_pkg::*;

  logic signed [OFS_BITS-1:0]   offset [LANES];
  logic [DEADBAND_BITS-1:0]     deadband;
  logic [COEFF_BITS-1:0]        coeff;
  logic                         primed;
  logic                         s1_valid;
  logic                         merge_ready;
  logic                         accept;
  logic                         take;
  logic [SAMPLE_BITS-1:0]       samp [LANES];
  logic signed [LEVEL_BITS-1:0] level [LANES];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset[LANE_LB] <= OFS_LB_RST;
      offset[LANE_RB] <= OFS_RB_RST;
      offset[LANE_RT] <= OFS_RT_RST;
      offset[LANE_LT] <= OFS_LT_RST;
      deadband        <= DEADBAND_RST;
      coeff           <= COEFF_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_OFS_LB:   offset[LANE_LB] <= cfg_data[OFS_BITS-1:0];
        CFG_OFS_RB:   offset[LANE_RB] <= cfg_data[OFS_BITS-1:0];
        CFG_OFS_RT:   offset[LANE_RT] <= cfg_data[OFS_BITS-1:0];
        CFG_OFS_LT:   offset[LANE_LT] <= cfg_data[OFS_BITS-1:0];
        CFG_DEADBAND: deadband        <= cfg_data[DEADBAND_BITS-1:0];
        CFG_COEFF:    coeff           <= cfg_data[COEFF_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Accept a request only when the level stage is empty or can hand off to the merge
  assign sample_ready = !s1_valid || merge_ready;
  assign accept       = sample_valid && sample_ready;
  assign take         = s1_valid && merge_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      primed   <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        primed   <= 1'b1;
      end else if (merge_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Split the request into lanes
  assign samp[LANE_LB] = sample.sample_left_bottom;
  assign samp[LANE_RB] = sample.sample_right_bottom;
  assign samp[LANE_RT] = sample.sample_right_top;
  assign samp[LANE_LT] = sample.sample_left_top;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    qst_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .load   (accept),
      .primed (primed),
      .sample (samp[i]),
      .offset (offset[i]),
      .coeff  (coeff),
      .level  (level[i])
    );
  end

  qst_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .ready       (merge_ready),
    .level       (level),
    .deadband    (deadband),
    .drive_valid (drive_valid),
    .drive_ready (drive_ready),
    .drive       (drive)
  );

`ifndef NO_ASSERTIONS
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted request did not reach the level stage");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !merge_ready |=> s1_valid && !$past(accept))
    else $error("level stage dropped a request while stalled");

  a_primed_sticks: assert property (@(posedge clk) disable iff (rst)
    primed |=> primed)
    else $error("filter lost its primed state");

  a_drive_code_legal: assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> (drive.tilt_drive == DRIVE_STOP || drive.tilt_drive == DRIVE_FWD ||
                     drive.tilt_drive == DRIVE_REV) &&
                    (drive.pan_drive == DRIVE_STOP || drive.pan_drive == DRIVE_FWD ||
                     drive.pan_drive == DRIVE_REV))
    else $error("drive code out of range");
`endif

endmodule

`default_nettype wire

// ===== test/quad_sensor_tracker_drive_top_tb.sv =====
// Self-checking bench for quad_sensor_tracker_drive_top: drives random and directed sensor sets
// through the valid/ready request channel and checks every tilt/pan result in order.
// Depends on qst_pkg and the quad_sensor_tracker_drive_top RTL.
`timescale 1ns / 1ps

module quad_sensor_tracker_drive_top_tb;
  import qst_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 110;
  localparam int SETTLE_CYCLES = 4;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;

  // Indexes past the register file; writes there must be ignored
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_7 = 3'd7;

  // Tracks register values and smoothed levels; queues the drive codes each request implies
  class drive_expectations;
    logic signed [OFS_BITS-1:0] offset [LANES];
    logic [DEADBAND_BITS-1:0]   deadband;
    logic [COEFF_BITS-1:0]      coeff;
    longint                     level [LANES];
    bit                         primed;
    drive_t                     pending_drives [$];

    function new();
      offset[LANE_LB] = OFS_LB_RST;
      offset[LANE_RB] = OFS_RB_RST;
      offset[LANE_RT] = OFS_RT_RST;
      offset[LANE_LT] = OFS_LT_RST;
      deadband = DEADBAND_RST;
      coeff = COEFF_RST;
      for (int i = 0; i < LANES; i++) level[i] = 0;
      primed = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_OFS_LB, CFG_OFS_RB, CFG_OFS_RT, CFG_OFS_LT: begin
          offset[idx] = data[OFS_BITS-1:0];
        end
        CFG_DEADBAND: begin
          deadband = data[DEADBAND_BITS-1:0];
        end
        CFG_COEFF: begin
          coeff = data[COEFF_BITS-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function longint clamp_level(longint v);
      if (v > longint'(32'h7FFF_FFFF)) return longint'(32'h7FFF_FFFF);
      if (v < -longint'(32'h8000_0000)) return -longint'(32'h8000_0000);
      return v;
    endfunction

    // Round a fixed-point pair sum to an integer, half away from zero
    function longint round_pair(longint v);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (longint'(1) <<< (FRAC_BITS_DEF - 1))) >>> FRAC_BITS_DEF;
      return (v < 0) ? -mag : mag;
    endfunction

    function logic [DRIVE_BITS-1:0] drive_code(longint diff);
      longint mag;
      mag = (diff < 0) ? -diff : diff;
      if (mag <= longint'(deadband)) return DRIVE_STOP;
      return (diff > 0) ? DRIVE_FWD : DRIVE_REV;
    endfunction

    function void note_request(sample_t s);
      logic [SAMPLE_BITS-1:0] raw [LANES];
      longint x, target, step, top, bottom, left, right;
      drive_t want;
      raw[LANE_LB] = s.sample_left_bottom;
      raw[LANE_RB] = s.sample_right_bottom;
      raw[LANE_RT] = s.sample_right_top;
      raw[LANE_LT] = s.sample_left_top;
      // Load on the first set, then move each level toward its target
      for (int i = 0; i < LANES; i++) begin
        x = longint'(raw[i]) + longint'(offset[i]);
        target = x <<< FRAC_BITS_DEF;
        if (!primed) begin
          level[i] = clamp_level(target);
        end else begin
          step = (target - level[i]) * longint'(coeff) + (longint'(1) <<< (COEFF_BITS - 1));
          level[i] = clamp_level(level[i] + (step >>> COEFF_BITS));
        end
      end
      primed = 1;
      top    = round_pair(level[LANE_RT] + level[LANE_LT]);
      bottom = round_pair(level[LANE_LB] + level[LANE_RB]);
      left   = round_pair(level[LANE_LB] + level[LANE_LT]);
      right  = round_pair(level[LANE_RB] + level[LANE_RT]);
      want.tilt_drive = drive_code(top - bottom);
      want.pan_drive  = drive_code(left - right);
      pending_drives.push_back(want);
    endfunction

    // Empty string when the result matches the oldest expectation
    function string check_drive(drive_t got);
      drive_t want;
      string msg;
      msg = "";
      if (pending_drives.size() == 0)
        return $sformatf("unexpected result tilt=%0d pan=%0d", got.tilt_drive, got.pan_drive);
      want = pending_drives.pop_front();
      if (got.tilt_drive !== want.tilt_drive)
        msg = $sformatf("tilt got %0d want %0d ", got.tilt_drive, want.tilt_drive);
      if (got.pan_drive !== want.pan_drive)
        msg = {msg, $sformatf("pan got %0d want %0d", got.pan_drive, want.pan_drive)};
      return msg;
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      sample_valid;
  logic                      sample_ready;
  sample_t                   sample_bus;
  logic                      drive_valid;
  logic                      drive_ready;
  drive_t                    drive_bus;

  drive_expectations ledger;
  int  cycle_count = 0;
  int  mismatch_count = 0;
  int  request_count = 0;
  int  result_count = 0;
  int  reg_write_count = 0;
  int  settings_count = 0;
  int  tilt_seen [4] = '{0, 0, 0, 0};
  int  pan_seen [4] = '{0, 0, 0, 0};
  bit  tx_gaps = 0;
  bit  rx_stalls = 0;
  bit  hold_request = 0;

  quad_sensor_tracker_drive_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample_bus),
    .drive_valid  (drive_valid),
    .drive_ready  (drive_ready),
    .drive        (drive_bus)
  );

  initial clk = 0;
  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("quad_sensor_tracker_drive_top test failed");
      $finish;
    end
  end

  task report_mismatch(string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Mostly back to back, sometimes a few cycles, rarely a long gap
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic sample_t make_sample(int lb, int rb, int rt, int lt);
    sample_t s;
    s.sample_left_bottom  = SAMPLE_BITS'(lb);
    s.sample_right_bottom = SAMPLE_BITS'(rb);
    s.sample_right_top    = SAMPLE_BITS'(rt);
    s.sample_left_top     = SAMPLE_BITS'(lt);
    return s;
  endfunction

  // Mix of biased scenes (one side brighter), flat noise and rail values
  function automatic sample_t random_sample();
    int kind, base, tilt, pan, i;
    int v [LANES];
    kind = $urandom_range(0, 99);
    base = $urandom_range(0, SAMPLE_MAX);
    tilt = int'($urandom_range(0, 3000)) - 1500;
    pan  = int'($urandom_range(0, 3000)) - 1500;
    for (i = 0; i < LANES; i++) begin
      if (kind < 15) begin
        v[i] = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
      end else if (kind < 50) begin
        v[i] = $urandom_range(0, SAMPLE_MAX);
      end else begin
        v[i] = base + int'($urandom_range(0, 63)) - 32;
        v[i] += (i == LANE_RT || i == LANE_LT) ? tilt : -tilt;
        v[i] += (i == LANE_LB || i == LANE_LT) ? pan : -pan;
        if (v[i] < 0) v[i] = 0;
        if (v[i] > SAMPLE_MAX) v[i] = SAMPLE_MAX;
      end
    end
    return make_sample(v[LANE_LB], v[LANE_RB], v[LANE_RT], v[LANE_LT]);
  endfunction

  // Called and returns at a falling edge; data is written at the rising edge in between
  task write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_write = 1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 0;
    ledger.write_reg(idx, data);
    reg_write_count++;
  endtask

  // Called and returns at a falling edge; valid stays up until the request is taken
  task send_sample(sample_t s, int gap);
    if (gap > 0) repeat (gap) @(negedge clk);
    sample_bus   = s;
    sample_valid = 1;
    do @(posedge clk); while (!sample_ready);
    ledger.note_request(s);
    request_count++;
    @(negedge clk);
    sample_valid = 0;
  endtask

  // Wait for every expected result, then let the pipeline settle
  task drain();
    while (ledger.pending() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result side: random stalls, plus one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    drive_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        drive_ready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 0;
      end else if (stall_left > 0) begin
        drive_ready = 0;
        stall_left--;
      end else begin
        drive_ready = 1;
        if (rx_stalls && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Check each accepted result
  always @(posedge clk) begin
    string msg;
    if (!rst && drive_valid && drive_ready) begin
      msg = ledger.check_drive(drive_bus);
      if (msg != "") report_mismatch(msg);
      result_count++;
      tilt_seen[drive_bus.tilt_drive]++;
      pan_seen[drive_bus.pan_drive]++;
    end
  end

  initial begin
    int p, n, r;
    logic [CFG_DATA_BITS-1:0] band_data, coeff_data;
    ledger = new();
    rst = 1;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data = '0;
    sample_valid = 0;
    sample_bus = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Reset settings: prime the filter, then push each side bright
    settings_count++;
    send_sample(make_sample(0, 0, 0, 0), 0);
    send_sample(make_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX), 0);
    send_sample(make_sample(0, 0, SAMPLE_MAX, SAMPLE_MAX), 0);
    send_sample(make_sample(SAMPLE_MAX, SAMPLE_MAX, 0, 0), 1);
    send_sample(make_sample(SAMPLE_MAX, 0, 0, SAMPLE_MAX), 0);
    send_sample(make_sample(0, SAMPLE_MAX, SAMPLE_MAX, 0), 2);
    drain();

    // Offset extremes and deadband zero, with junk in the upper data bits;
    // full-weight smoothing; writes past the register file
    settings_count++;
    write_reg(CFG_OFS_LB, 16'hF800);
    write_reg(CFG_OFS_RB, 16'h07FF);
    write_reg(CFG_OFS_RT, 16'h0800);
    write_reg(CFG_OFS_LT, 16'hF7FF);
    write_reg(CFG_DEADBAND, 16'hC000);
    write_reg(CFG_COEFF, 16'hFFFF);
    write_reg(CFG_SPARE_6, 16'hFFFF);
    write_reg(CFG_SPARE_7, 16'hFFFF);
    send_sample(make_sample(0, 0, SAMPLE_MAX, SAMPLE_MAX), 0);
    send_sample(make_sample(SAMPLE_MAX, SAMPLE_MAX, 0, 0), 0);
    send_sample(make_sample(SAMPLE_MAX, 0, 0, SAMPLE_MAX), 0);
    send_sample(make_sample(0, SAMPLE_MAX, SAMPLE_MAX, 0), 0);
    send_sample(make_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX), 0);
    send_sample(make_sample(0, 0, 0, 0), 0);
    drain();

    // Zero weight freezes the levels; widest deadband, then none
    settings_count++;
    write_reg(CFG_OFS_LB, 16'h0000);
    write_reg(CFG_OFS_RB, 16'h0000);
    write_reg(CFG_OFS_RT, 16'h0000);
    write_reg(CFG_OFS_LT, 16'h0000);
    write_reg(CFG_COEFF, 16'h0000);
    write_reg(CFG_DEADBAND, 16'h3FFF);
    send_sample(make_sample(SAMPLE_MAX, SAMPLE_MAX, 0, 0), 0);
    send_sample(make_sample(0, SAMPLE_MAX, SAMPLE_MAX, 0), 0);
    send_sample(make_sample(SAMPLE_MAX, 0, SAMPLE_MAX, 0), 0);
    send_sample(make_sample(0, SAMPLE_MAX, 0, SAMPLE_MAX), 0);
    drain();
    settings_count++;
    write_reg(CFG_DEADBAND, 16'h0000);
    send_sample(make_sample(SAMPLE_MAX, 0, 0, SAMPLE_MAX), 0);
    send_sample(make_sample(0, 0, SAMPLE_MAX, SAMPLE_MAX), 0);
    send_sample(make_sample(1, 2, 4, 8), 0);
    send_sample(make_sample(2048, 1024, 512, 256), 0);
    drain();

    // Random phases, each under fresh settings
    for (p = 0; p < PHASES; p++) begin
      settings_count++;
      r = $urandom_range(0, 99);
      if (p == 0) begin
        band_data  = 16'h0000;
        coeff_data = 16'hFFFF;
      end else if (p == 1) begin
        band_data  = 16'hFFFF;
        coeff_data = 16'h0001;
      end else begin
        if (r < 15) band_data = 16'h0000;
        else if (r < 25) band_data = 16'hFFFF;
        else band_data = CFG_DATA_BITS'($urandom_range(0, 600) |
                                        ($urandom_range(0, 3) << DEADBAND_BITS));
        r = $urandom_range(0, 99);
        if (r < 10) coeff_data = 16'h0000;
        else if (r < 20) coeff_data = 16'h0001;
        else if (r < 30) coeff_data = 16'hFFFF;
        else coeff_data = CFG_DATA_BITS'($urandom_range(2000, 65535));
      end
      write_reg(CFG_OFS_LB, CFG_DATA_BITS'($urandom()));
      write_reg(CFG_OFS_RB, CFG_DATA_BITS'($urandom()));
      write_reg(CFG_OFS_RT, CFG_DATA_BITS'($urandom()));
      write_reg(CFG_OFS_LT, CFG_DATA_BITS'($urandom()));
      write_reg(CFG_DEADBAND, band_data);
      write_reg(CFG_COEFF, coeff_data);
      if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE_6, CFG_DATA_BITS'($urandom()));
      if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE_7, CFG_DATA_BITS'($urandom()));

      // One phase runs with no idling on either side
      tx_gaps   = (p != 2);
      rx_stalls = (p != 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Stop the result side for a long stretch and keep offering requests
        if (p == 4 && n == 20) hold_request = 1;
        send_sample(random_sample(), (tx_gaps && !hold_request) ? pick_gap() : 0);
      end
      drain();
    end

    $display("covered %0d requests and %0d results over %0d register settings (%0d writes)",
             request_count, result_count, settings_count, reg_write_count);
    $display("tilt stop/fwd/rev %0d/%0d/%0d, pan stop/fwd/rev %0d/%0d/%0d",
             tilt_seen[DRIVE_STOP], tilt_seen[DRIVE_FWD], tilt_seen[DRIVE_REV],
             pan_seen[DRIVE_STOP], pan_seen[DRIVE_FWD], pan_seen[DRIVE_REV]);
    if (mismatch_count == 0 && ledger.pending() == 0) begin
      $display("quad_sensor_tracker_drive_top test passed");
    end else begin
      $display("quad_sensor_tracker_drive_top test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/qst_pkg.sv
sv/qst_lane.sv
sv/qst_merge.sv
sv/quad_sensor_tracker_drive_top.sv
test/quad_sensor_tracker_drive_top_tb.sv
